// File: rtl/assert_macros.svh
// Assertion macros used by the directory entry parser top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, prop)
`define ASSERT_NEVER(label, expr)
`endif
`endif

// File: rtl/fat_dep_pkg.sv
// Shared constants and types of the directory entry parser.
package fat_dep_pkg;

   localparam int COUNT_BITS = 16;
   localparam int POS_W      = 5;
   localparam int NAME_LEN   = 11;
   localparam int BASE_LEN   = 8;
   localparam int EXT_LEN    = 3;
   localparam int RSP_DATA_W = 176;

   localparam logic [7:0] BYTE_END       = 8'h00;
   localparam logic [7:0] BYTE_DELETED   = 8'hE5;
   localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;
   localparam logic [7:0] ATTR_VOLUME    = 8'h08;
   localparam logic [7:0] ATTR_DIRECTORY = 8'h10;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;

   localparam logic [15:0] MAX_ENTRIES_RESET = 16'hFFFF;

   localparam logic [POS_W-1:0] POS_FIRST   = 5'd0;
   localparam logic [POS_W-1:0] POS_ATTR    = 5'd11;
   localparam logic [POS_W-1:0] POS_CLUS_H0 = 5'd20;
   localparam logic [POS_W-1:0] POS_CLUS_H1 = 5'd21;
   localparam logic [POS_W-1:0] POS_CLUS_L0 = 5'd26;
   localparam logic [POS_W-1:0] POS_CLUS_L1 = 5'd27;
   localparam logic [POS_W-1:0] POS_SIZE_0  = 5'd28;
   localparam logic [POS_W-1:0] POS_LAST    = 5'd31;

   // Status a name cell gives to the trimming chain.
   typedef struct packed {
      logic zero_out;   // a zero byte was seen at or before this cell
      logic tail_out;   // a character other than space or zero stands at or after this cell
      logic keep;       // this character survives trimming
   } cell_status_type;

endpackage

// File: rtl/fat_dir_entry_parser_unit.sv
// Directory entry parser top level: byte capture, entry decode and result register.
// A result is offered in the cycle after the beat carrying an entry's last byte, or
// an end marker. Throughput: one byte beat per cycle unless an untaken result stalls,
// set by the eleven-cell name row and single result register that drains as it loads.
// Reset clears byte position, entry count, listing-done flag and result valid, and sets
// max_entries to 65535; captured entry bytes are not cleared.
`include "assert_macros.svh"
module fat_dir_entry_parser_unit
   import fat_dep_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input beats.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // data_byte[7:0]
   input  logic                  req_tuser,   // restart[0]
   // Result beats.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // base_name[63:0], base_length[67:64], ext_name[91:68], ext_length[93:92],
   // start_cluster[125:94], file_size[157:126], is_dir[158], entry_count[174:159],
   // zero pad[175]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,   // end_of_directory[0]
   output logic                  rsp_tlast,
   // Configuration register max_entries.
   input  logic                  csr_write_enable,
   input  logic [15:0]           csr_write_data
);

   // Control state.
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  done_ff, done_in;
   logic [15:0]           max_entries_ff;

   // Entry fields outside the name row; these are payload and need no reset. The top
   // size byte is taken straight from the closing beat, so only three are held.
   logic [7:0]            attr_ff;
   logic [31:0]           cluster_ff;
   logic [23:0]           size_ff;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_eod_ff, rsp_eod_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  in_fire;
   logic                  restart;
   logic [POS_W-1:0]      eff_pos;
   logic [COUNT_BITS-1:0] eff_count;
   logic                  eff_done;
   logic                  active;
   logic                  end_hit;
   logic                  entry_end;
   logic                  shift_en;
   logic                  skip;
   logic                  report;
   logic                  result_load;
   logic [COUNT_BITS-1:0] count_inc;
   logic [31:0]           limit;
   logic                  limit_hit;
   logic [31:0]           size_full;
   logic [7:0]            data_byte;

   // Name row wiring.
   logic [7:0]            cell_char [NAME_LEN];
   logic [7:0]            cell_feed [NAME_LEN];
   logic                  cell_zero_in [NAME_LEN];
   logic                  cell_tail_in [NAME_LEN];
   cell_status_type       cell_status [NAME_LEN];
   logic [BASE_LEN-1:0]   base_keep;
   logic [EXT_LEN-1:0]    ext_keep;
   logic [3:0]            base_length;
   logic [1:0]            ext_length;
   logic [63:0]           base_name;
   logic [23:0]           ext_name;

   assign data_byte  = req_tdata;
   assign restart    = req_tuser;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign in_fire    = req_tvalid && req_tready;

   // A restart clears position, count and the done flag before its own byte is taken.
   assign eff_pos   = restart ? '0 : pos_ff;
   assign eff_count = restart ? '0 : count_ff;
   assign eff_done  = restart ? 1'b0 : done_ff;
   assign active    = in_fire && !eff_done;
   assign end_hit   = active && (eff_pos == POS_FIRST) && (data_byte == BYTE_END);
   assign entry_end = active && !end_hit && (eff_pos == POS_LAST);
   assign shift_en  = active && !end_hit && (eff_pos < POS_ATTR);

   // The eleven name characters move one cell down per name byte, so that after
   // the eleventh byte the first character sits in cell zero.
   for (genvar k = 0; k < NAME_LEN; k++) begin : g_name
      if (k == NAME_LEN - 1) begin : g_feed_in
         assign cell_feed[k] = data_byte;
      end else begin : g_feed_next
         assign cell_feed[k] = cell_char[k+1];
      end

      // The base part and the extension are trimmed as two separate chains.
      if (k == 0 || k == BASE_LEN) begin : g_zero_head
         assign cell_zero_in[k] = 1'b0;
      end else begin : g_zero_link
         assign cell_zero_in[k] = cell_status[k-1].zero_out;
      end
      if (k == BASE_LEN - 1 || k == NAME_LEN - 1) begin : g_tail_head
         assign cell_tail_in[k] = 1'b0;
      end else begin : g_tail_link
         assign cell_tail_in[k] = cell_status[k+1].tail_out;
      end

      fat_dep_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .byte_in  (cell_feed[k]),
         .zero_in  (cell_zero_in[k]),
         .tail_in  (cell_tail_in[k]),
         .byte_out (cell_char[k]),
         .status   (cell_status[k])
      );

      if (k < BASE_LEN) begin : g_base
         assign base_keep[k]        = cell_status[k].keep;
         assign base_name[8*k +: 8] = cell_status[k].keep ? cell_char[k] : 8'h00;
      end else begin : g_ext
         assign ext_keep[k-BASE_LEN]             = cell_status[k].keep;
         assign ext_name[8*(k-BASE_LEN) +: 8] = cell_status[k].keep ? cell_char[k] : 8'h00;
      end
   end

   // Kept characters always form a prefix, so their count is the trimmed length.
   assign base_length = 4'($countones(base_keep));
   assign ext_length  = 2'($countones(ext_keep));

   assign skip = (cell_char[0] == BYTE_DELETED) || (attr_ff == ATTR_LONG_NAME)
              || ((attr_ff & ATTR_VOLUME) != 8'h00);
   assign report = entry_end && !skip && !((base_length == 4'd0) && (ext_length == 2'd0));

   // A limit of zero behaves as a limit of one.
   assign count_inc = eff_count + 1'b1;
   assign limit     = (max_entries_ff == 16'd0) ? 32'd1 : 32'(max_entries_ff);
   assign limit_hit = 32'(count_inc) >= limit;

   // The last size byte arrives on the same beat that closes the entry.
   assign size_full   = {data_byte, size_ff};
   assign result_load = end_hit || report;

   always_comb begin
      pos_in   = pos_ff;
      count_in = count_ff;
      done_in  = done_ff;
      if (in_fire) begin
         count_in = report ? count_inc : eff_count;
         done_in  = eff_done || end_hit || (report && limit_hit);
         if (!eff_done) begin
            pos_in = eff_pos + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_data_in = '0;
      rsp_eod_in  = 1'b0;
      rsp_last_in = 1'b0;
      if (end_hit) begin
         rsp_data_in[174:159] = 16'(eff_count);
         rsp_eod_in           = 1'b1;
         rsp_last_in          = 1'b1;
      end else begin
         rsp_data_in[63:0]    = base_name;
         rsp_data_in[67:64]   = base_length;
         rsp_data_in[91:68]   = ext_name;
         rsp_data_in[93:92]   = ext_length;
         rsp_data_in[125:94]  = cluster_ff;
         rsp_data_in[157:126] = size_full;
         rsp_data_in[158]     = (attr_ff & ATTR_DIRECTORY) != 8'h00;
         rsp_data_in[174:159] = 16'(count_inc);
         rsp_last_in          = limit_hit;
      end
   end

   assign rsp_valid_in = result_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         count_ff       <= '0;
         done_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         max_entries_ff <= MAX_ENTRIES_RESET;
      end else begin
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            max_entries_ff <= csr_write_data;
         end
      end
   end

   // Capture of the attribute, cluster halves and lower size bytes by entry position.
   always_ff @(posedge clock) begin
      if (active && !end_hit) begin
         unique case (eff_pos) inside
            POS_ATTR:    attr_ff            <= data_byte;
            POS_CLUS_H0: cluster_ff[23:16]  <= data_byte;
            POS_CLUS_H1: cluster_ff[31:24]  <= data_byte;
            POS_CLUS_L0: cluster_ff[7:0]    <= data_byte;
            POS_CLUS_L1: cluster_ff[15:8]   <= data_byte;
            [POS_SIZE_0:POS_LAST - 5'd1]: size_ff[{eff_pos[1:0], 3'b000} +: 8] <= data_byte;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_eod_ff  <= rsp_eod_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_eod_ff;
   assign rsp_tlast  = rsp_last_ff;

   // An end marker result always closes the listing.
   `ASSERT_PROP(a_eod_is_last, (rsp_valid_ff && rsp_eod_ff) |-> rsp_last_ff)
   // Once the listing has ended, plain bytes never produce a result.
   `ASSERT_NEVER(a_quiet_after_end, done_ff && in_fire && !restart && result_load)
   // A byte taken inside a running listing advances the position by one.
   `ASSERT_PROP(a_pos_step, (in_fire && !restart && !done_ff) |=> (pos_ff == 5'($past(pos_ff) + 5'd1)))
   // With the result register empty the block always takes a byte.
   `ASSERT_PROP(a_ready_when_empty, !rsp_valid_ff |-> req_tready)

endmodule

// File: rtl/fat_dep_cell.sv
// One name character cell: holds a byte, shifts it on and joins the trimming chain.
module fat_dep_cell
   import fat_dep_pkg::*;
(
   input  logic            clock,
   input  logic            shift_en,
   input  logic [7:0]      byte_in,
   input  logic            zero_in,
   input  logic            tail_in,
   output logic [7:0]      byte_out,
   output cell_status_type status
);

   logic [7:0] char_ff;
   logic       is_zero;
   logic       live;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         char_ff <= byte_in;
      end
   end

   // A character is live when it is neither a space nor a zero; a live character past
   // an embedded zero still stops the trailing trim of the cells before that zero.
   assign is_zero         = (char_ff == BYTE_END);
   assign live            = !is_zero && (char_ff != CHAR_SPACE);
   assign status.zero_out = zero_in | is_zero;
   assign status.tail_out = tail_in | live;
   assign status.keep     = !zero_in && !is_zero && (live || tail_in);
   assign byte_out        = char_ff;

endmodule

// File: sim/fat_dir_listing_monitor.sv
// Monitor for the directory entry parser: predicts listing results and compares result beats.
module fat_dir_listing_monitor
   import fat_dep_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  rsp_tlast,
   input  logic                  csr_write_enable,
   input  logic [15:0]           csr_write_data,
   output int unsigned           mismatch_count,
   output int unsigned           pending_count,
   output int unsigned           checked_results,
   output int unsigned           end_markers,
   output int unsigned           limit_ends,
   output int unsigned           byte_beats
);

   // Layout of rsp_tdata, highest field first.
   typedef struct packed {
      logic                  pad;
      logic [15:0]           entry_count;
      logic                  is_dir;
      logic [31:0]           file_size;
      logic [31:0]           start_cluster;
      logic [1:0]            ext_length;
      logic [23:0]           ext_name;
      logic [3:0]            base_length;
      logic [63:0]           base_name;
   } entry_word_type;

   typedef struct packed {
      logic           end_marker;
      logic           final_flag;
      entry_word_type word;
   } listing_result_type;

   logic [POS_W-1:0]      byte_pos;
   logic [8*NAME_LEN-1:0] name_chars;
   logic [7:0]            attr_byte;
   logic [31:0]           cluster_word;
   logic [31:0]           size_word;
   logic [COUNT_BITS-1:0] reported;
   logic                  listing_over;
   logic [15:0]           entry_limit;
   listing_result_type    expected_results[$];
   int unsigned           mismatches;
   int unsigned           checked;
   int unsigned           markers;
   int unsigned           limits;
   int unsigned           taken;

   // Length of a name part once trailing spaces and zeros are gone, cut at the first zero.
   function automatic int unsigned trimmed_len(input logic [8*NAME_LEN-1:0] chars,
                                               input int first, input int count);
      int stop;
      stop = count;
      while (stop > 0 && (chars[8*(first+stop-1) +: 8] == CHAR_SPACE ||
                          chars[8*(first+stop-1) +: 8] == BYTE_END))
         stop--;
      for (int k = 0; k < stop; k++)
         if (chars[8*(first+k) +: 8] == BYTE_END) return k;
      return stop;
   endfunction

   function automatic logic [63:0] packed_chars(input logic [8*NAME_LEN-1:0] chars,
                                                input int first, input int count);
      logic [63:0] v;
      v = '0;
      for (int k = 0; k < count; k++)
         v[8*k +: 8] = chars[8*(first+k) +: 8];
      return v;
   endfunction

   task automatic take_dir_byte(input logic [7:0] value, input logic restart);
      listing_result_type r;
      int unsigned        base_len;
      int unsigned        ext_len;
      logic [POS_W-1:0]   pos;
      logic [15:0]        limit;
      taken++;
      if (restart) begin
         byte_pos     = '0;
         reported     = '0;
         listing_over = 1'b0;
      end
      if (listing_over) return;
      pos      = byte_pos;
      byte_pos = pos + 1'b1;
      r        = '0;
      if (pos == POS_FIRST && value == BYTE_END) begin
         r.end_marker       = 1'b1;
         r.final_flag       = 1'b1;
         r.word.entry_count = reported[15:0];
         listing_over       = 1'b1;
         expected_results.push_back(r);
         return;
      end
      if (pos < NAME_LEN) name_chars[8*pos +: 8] = value;
      else if (pos == POS_ATTR) attr_byte = value;
      else if (pos == POS_CLUS_H0) cluster_word[23:16] = value;
      else if (pos == POS_CLUS_H1) cluster_word[31:24] = value;
      else if (pos == POS_CLUS_L0) cluster_word[7:0] = value;
      else if (pos == POS_CLUS_L1) cluster_word[15:8] = value;
      else if (pos >= POS_SIZE_0) size_word[8*(pos-POS_SIZE_0) +: 8] = value;
      if (pos != POS_LAST) return;
      if (name_chars[7:0] == BYTE_DELETED || attr_byte == ATTR_LONG_NAME ||
          (attr_byte & ATTR_VOLUME) != 8'h00)
         return;
      base_len = trimmed_len(name_chars, 0, BASE_LEN);
      ext_len  = trimmed_len(name_chars, BASE_LEN, EXT_LEN);
      if (base_len == 0 && ext_len == 0) return;
      reported = reported + 1'b1;
      limit    = (entry_limit == 16'd0) ? 16'd1 : entry_limit;
      r.word.base_name     = packed_chars(name_chars, 0, base_len);
      r.word.base_length   = base_len[3:0];
      r.word.ext_name      = 24'(packed_chars(name_chars, BASE_LEN, ext_len));
      r.word.ext_length    = ext_len[1:0];
      r.word.start_cluster = cluster_word;
      r.word.file_size     = size_word;
      r.word.is_dir        = (attr_byte & ATTR_DIRECTORY) != 8'h00;
      r.word.entry_count   = reported[15:0];
      if (reported >= limit) begin
         r.final_flag = 1'b1;
         listing_over = 1'b1;
      end
      expected_results.push_back(r);
   endtask

   task automatic compare_field(input string label, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
      end
   endtask

   task automatic check_result_beat();
      listing_result_type want;
      entry_word_type     got;
      got = rsp_tdata;
      if (expected_results.size() == 0) begin
         mismatches++;
         $display("%0t: result beat expected none, got data %h", $time, rsp_tdata);
         return;
      end
      want = expected_results.pop_front();
      checked++;
      if (want.end_marker) markers++;
      else if (want.final_flag) limits++;
      compare_field("base_name", want.word.base_name, got.base_name);
      compare_field("base_length", want.word.base_length, got.base_length);
      compare_field("ext_name", want.word.ext_name, got.ext_name);
      compare_field("ext_length", want.word.ext_length, got.ext_length);
      compare_field("start_cluster", want.word.start_cluster, got.start_cluster);
      compare_field("file_size", want.word.file_size, got.file_size);
      compare_field("is_dir", want.word.is_dir, got.is_dir);
      compare_field("entry_count", want.word.entry_count, got.entry_count);
      compare_field("pad", want.word.pad, got.pad);
      compare_field("end_of_directory", want.end_marker, rsp_tuser);
      compare_field("last", want.final_flag, rsp_tlast);
   endtask

   // A result beat always belongs to an earlier byte, so it is checked before the byte
   // taken at the same edge is predicted.
   always @(posedge clock) begin
      if (reset) begin
         byte_pos     = '0;
         reported     = '0;
         listing_over = 1'b0;
         entry_limit  = MAX_ENTRIES_RESET;
         expected_results.delete();
      end else begin
         if (csr_write_enable) entry_limit = csr_write_data;
         if (rsp_tvalid && rsp_tready) check_result_beat();
         if (req_tvalid && req_tready) take_dir_byte(req_tdata, req_tuser);
      end
      mismatch_count  <= mismatches;
      pending_count   <= expected_results.size();
      checked_results <= checked;
      end_markers     <= markers;
      limit_ends      <= limits;
      byte_beats      <= taken;
   end

endmodule

// File: sim/tb.sv
// Testbench top for the directory entry parser: stimulus, ready pattern, watchdog and verdict.
module tb;
   import fat_dep_pkg::*;

   // Run length: stimulus stops once this many byte beats have been taken, whether a
   // listing was running or not, and a few dozen results have been checked.
   localparam int unsigned BYTE_TARGET   = 1900;
   localparam int unsigned RESULT_TARGET = 48;
   // Cycles without any beat on either channel before the run is declared hung. The
   // longest correct quiet stretch is a long sender gap or receiver stall plus a settling
   // pause, so this is many times over.
   localparam int unsigned STALL_LIMIT   = 2000;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_tvalid       = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata        = 8'h00;
   logic                  req_tuser        = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready       = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_write_enable = 1'b0;
   logic [15:0]           csr_write_data   = 16'h0000;

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned checked_results;
   int unsigned end_markers;
   int unsigned limit_ends;
   int unsigned byte_beats;

   // Set by the stimulus to give stretches without any idling on either side.
   bit          calm_sender   = 1'b0;
   bit          calm_receiver = 1'b0;
   int unsigned stall_left    = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned csr_writes    = 0;

   fat_dir_entry_parser_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .rsp_tlast        (rsp_tlast),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // The monitor sits beside the block, sees both channels and the register port, and
   // hands back its failure and bookkeeping counts.
   fat_dir_listing_monitor entry_monitor (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .rsp_tlast        (rsp_tlast),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count),
      .checked_results  (checked_results),
      .end_markers      (end_markers),
      .limit_ends       (limit_ends),
      .byte_beats       (byte_beats)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Gap lengths: mostly none, often short, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver side: ready drops for random stretches unless the receiver is calm.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm_receiver && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   // Watchdog: any beat on either channel restarts the count of quiet cycles.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   // One byte beat, preceded by a random gap. Valid stays high on return so that a
   // following beat with no gap goes out on the very next cycle.
   task automatic send_byte(input logic [7:0] value, input logic restart);
      int unsigned gap;
      gap = calm_sender ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= restart;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_entry(input logic [255:0] entry, input logic restart);
      for (int k = 0; k < 32; k++)
         send_byte(entry[8*k +: 8], restart && k == 0);
   endtask

   // Drops valid and waits until every predicted result has been taken, then pauses so
   // that an entry giving no result is also finished.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_max_entries(input logic [15:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      csr_writes++;
   endtask

   // An 8.3 name from text, padded with spaces to eleven characters.
   function automatic logic [8*NAME_LEN-1:0] text_name(input string s);
      logic [8*NAME_LEN-1:0] nm;
      for (int k = 0; k < NAME_LEN; k++)
         nm[8*k +: 8] = (k < s.len()) ? s[k] : CHAR_SPACE;
      return nm;
   endfunction

   // A 32-byte entry with the given fields; the reserved and time bytes are random.
   function automatic logic [255:0] make_entry(input logic [8*NAME_LEN-1:0] nm,
                                               input logic [7:0] attr,
                                               input logic [31:0] cluster,
                                               input logic [31:0] size);
      logic [255:0] e;
      for (int k = 0; k < 8; k++) e[32*k +: 32] = $urandom;
      e[8*NAME_LEN-1:0] = nm;
      e[95:88]          = attr;
      e[8*20 +: 16]     = cluster[31:16];
      e[8*26 +: 16]     = cluster[15:0];
      e[8*28 +: 32]     = size;
      return e;
   endfunction

   // A plausible entry most of the time: printable base and extension of random length
   // padded with spaces or zeros, ordinary attributes. Now and then fully random name
   // bytes, an embedded zero, a deleted marker, a long-name or volume attribute.
   function automatic logic [255:0] random_entry();
      logic [8*NAME_LEN-1:0] nm;
      logic [7:0]            attr;
      int unsigned           base_len;
      int unsigned           ext_len;
      int unsigned           roll;
      base_len = $urandom_range(0, BASE_LEN);
      ext_len  = $urandom_range(0, EXT_LEN);
      for (int k = 0; k < NAME_LEN; k++) begin
         if ((k < BASE_LEN) ? (k < base_len) : (k - BASE_LEN < ext_len))
            nm[8*k +: 8] = 8'($urandom_range(33, 126));
         else
            nm[8*k +: 8] = ($urandom_range(0, 3) == 0) ? BYTE_END : CHAR_SPACE;
      end
      roll = $urandom_range(0, 9);
      if (roll == 0) nm = 88'({$urandom, $urandom, $urandom});
      else if (roll == 1) nm[8*$urandom_range(0, NAME_LEN-1) +: 8] = BYTE_END;
      if ($urandom_range(0, 11) == 0) nm[7:0] = BYTE_DELETED;
      roll = $urandom_range(0, 19);
      if (roll < 12) attr = 8'($urandom & 8'h37);
      else if (roll < 14) attr = ATTR_LONG_NAME;
      else if (roll < 16) attr = 8'($urandom | ATTR_VOLUME);
      else attr = 8'($urandom);
      return make_entry(nm, attr, $urandom, $urandom);
   endfunction

   initial begin : stimulus
      logic [8*NAME_LEN-1:0] nm;
      logic [255:0]          entry;
      logic [15:0]           limit_value;
      int unsigned           roll;
      int unsigned           count;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed listing straight after reset, with no restart beat: the block must
      // start at byte zero on its own.
      send_entry(make_entry(text_name("README  TXT"), 8'h20, 32'hFFFF_FFFF, 32'h0), 1'b0);
      // Full-length name, directory flag, largest size.
      send_entry(make_entry(text_name("ABCDEFGHXYZ"), ATTR_DIRECTORY, 32'h0,
                            32'hFFFF_FFFF), 1'b0);
      // Deleted, long-name and volume-label entries are all skipped.
      nm = text_name("GONE    TXT");
      nm[7:0] = BYTE_DELETED;
      send_entry(make_entry(nm, 8'h20, $urandom, $urandom), 1'b0);
      send_entry(make_entry(text_name("LONGNAMEXYZ"), ATTR_LONG_NAME, $urandom, $urandom),
                 1'b0);
      send_entry(make_entry(text_name("VOLUME"), ATTR_VOLUME, $urandom, $urandom), 1'b0);
      // Embedded zeros cut both parts short: base "AB", extension "T".
      nm = text_name("ABxCD   TxX");
      nm[8*2 +: 8] = BYTE_END;
      nm[8*9 +: 8] = BYTE_END;
      send_entry(make_entry(nm, 8'h01, 32'h0001_0002, 32'h0000_0100), 1'b0);
      // A space before an embedded zero is kept when a character follows the zero.
      nm = text_name("A xB    ");
      nm[8*2 +: 8] = BYTE_END;
      send_entry(make_entry(nm, 8'h00, 32'h0000_0003, 32'h0000_0004), 1'b0);
      // Empty base with an extension is still reported; all spaces is not.
      send_entry(make_entry(text_name("        DAT"), 8'h00, 32'h8000_0000, 32'h1), 1'b0);
      send_entry(make_entry(text_name(""), 8'h00, $urandom, $urandom), 1'b0);
      // Top-bit base characters, mixed extension bytes, then a name padded with zeros.
      send_entry(make_entry({24'h017F80, 64'hFFFF_FFFF_FFFF_FFFF}, 8'h30, 32'h1234_5678,
                            32'h8000_0001), 1'b0);
      nm = text_name("FILE");
      nm[8*NAME_LEN-1:32] = '0;
      send_entry(make_entry(nm, 8'h04, 32'h0000_FFFF, 32'hFFFF_0000), 1'b0);
      // End marker, then bytes that must be ignored until the next restart.
      send_byte(BYTE_END, 1'b0);
      send_byte(BYTE_END, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'hFF, 1'b0);

      // A limit of one: the first entry closes the listing, the second is ignored.
      write_max_entries(16'd1);
      send_entry(make_entry(text_name("ONLY    ONE"), 8'h20, $urandom, $urandom), 1'b1);
      send_entry(make_entry(text_name("EXTRA   TXT"), 8'h20, $urandom, $urandom), 1'b0);

      // A limit of three, with a restart landing in the middle of an entry.
      write_max_entries(16'd3);
      entry = make_entry(text_name("HALF    BIN"), 8'h20, $urandom, $urandom);
      for (int k = 0; k < 10; k++) send_byte(entry[8*k +: 8], k == 0);
      for (int k = 0; k < 3; k++) send_entry(random_entry() & ~256'hFF | 256'h41, k == 0);
      // A restart beat that is itself an end marker reports an empty listing.
      send_byte(BYTE_END, 1'b1);
      write_max_entries(MAX_ENTRIES_RESET);

      // Random listings until enough byte beats and results have gone through. Each
      // listing begins with a restart beat, so entries realign after broken ones.
      while (byte_beats < BYTE_TARGET || checked_results < RESULT_TARGET) begin
         roll          = $urandom_range(0, 9);
         calm_sender   = ($urandom_range(0, 5) == 0);
         calm_receiver = ($urandom_range(0, 5) == 0);
         if (roll < 3) begin
            case ($urandom_range(0, 4))
               0: limit_value = 16'd1;
               1: limit_value = 16'($urandom_range(2, 6));
               2: limit_value = MAX_ENTRIES_RESET;
               default: limit_value = 16'($urandom_range(1, 65535));
            endcase
            write_max_entries(limit_value);
         end else if (roll == 3) begin
            settle();
         end
         if (roll == 9) begin
            // Noise: loose bytes with the odd restart among them.
            count = $urandom_range(1, 40);
            for (int k = 0; k < count; k++)
               send_byte(8'($urandom), $urandom_range(0, 9) == 0);
         end else begin
            count = $urandom_range(1, 10);
            for (int k = 0; k < count; k++) send_entry(random_entry(), k == 0);
            case ($urandom_range(0, 3))
               0: begin
                  send_byte(BYTE_END, 1'b0);
                  for (int k = 0; k < 3; k++) send_byte(8'($urandom), 1'b0);
               end
               1: begin
                  entry = random_entry();
                  count = $urandom_range(1, 31);
                  for (int k = 0; k < count; k++) send_byte(entry[8*k +: 8], 1'b0);
               end
               default: ;
            endcase
         end
      end

      // Drain: every predicted result must arrive, then a pause for strays.
      calm_receiver = 1'b0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("summary: %0d directory bytes taken, %0d results checked, %0d register writes",
               byte_beats, checked_results, csr_writes);
      $display("summary: %0d listings closed by end marker, %0d by entry limit",
               end_markers, limit_ends);
      if (mismatch_count == 0 && pending_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

// File: fat_dir_entry_parser_unit.f
+incdir+rtl
rtl/fat_dep_pkg.sv
rtl/fat_dep_cell.sv
rtl/fat_dir_entry_parser_unit.sv
sim/fat_dir_listing_monitor.sv
sim/tb.sv
